// ===== rtl/sha256_hasher_unit_defines.svh =====
// ============================================================================
// SHA-256 hasher assertion macros
// Shared concurrent assertion forms for the checker file.
// ============================================================================
`ifndef SHA256_HASHER_UNIT_DEFINES_SVH
`define SHA256_HASHER_UNIT_DEFINES_SVH

// Assertion with reset qualification
`define SHA256H_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that stays active through reset
`define SHA256H_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sha256h_pkg.sv =====
// ============================================================================
// SHA-256 hasher package
// Transaction types, round constants, initial hash values and the SHA-256 mixing functions.
// ============================================================================
package sha256h_pkg;

    localparam logic [5:0] LEN_FILL_LIMIT = 6'd56;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        case (idx)
            3'd0: init_h = 32'h6a09e667;
            3'd1: init_h = 32'hbb67ae85;
            3'd2: init_h = 32'h3c6ef372;
            3'd3: init_h = 32'ha54ff53a;
            3'd4: init_h = 32'h510e527f;
            3'd5: init_h = 32'h9b05688c;
            3'd6: init_h = 32'h1f83d9ab;
            default: init_h = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

// ===== rtl/sha256h_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, registered read data.
// ============================================================================
module sha256h_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sha256_hasher_unit.sv =====
// ============================================================================
// SHA-256 hasher unit
// Streaming SHA-256 engine: byte input, eight-word digest output.
// ============================================================================
// Message bytes are taken one per cycle while a 64-byte block fills; four
// bytes are packed into a word and written to a 16-word message RAM. A full
// block is then compressed in three steps (loading the message words and the
// chaining state from the 8-word state RAM, 64 rounds, adding back), during
// which no transaction is accepted. An end-of-message transaction pads the
// block at one word per cycle and runs one or two further compressions, then
// emits the eight digest words, word 0 first, via the OUT_RD and OUT_LD states.
module sha256_hasher_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sha256h_pkg::t_in   i_in,
    output logic               o_valid,
    input  logic               i_ready,
    output sha256h_pkg::t_out  o_out
);
    import sha256h_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PAD    = 7'b0000010,
        ST_LOAD   = 7'b0000100,
        ST_ROUND  = 7'b0001000,
        ST_ADD    = 7'b0010000,
        ST_OUT_RD = 7'b0100000,
        ST_OUT_LD = 7'b1000000
    } t_state;

    t_state       r_state, n_state;
    logic [4:0]   r_cnt, n_cnt;
    logic [5:0]   r_rnd, n_rnd;
    logic [3:0]   r_widx, n_widx;
    logic [5:0]   r_fill, n_fill;
    logic [54:0]  r_blocks, n_blocks;
    logic [23:0]  r_acc, n_acc;
    logic         r_h_init, n_h_init;
    logic         r_eom, n_eom;
    logic         r_pad_first, n_pad_first;
    logic         r_fin_blk, n_fin_blk;
    logic [31:0]  r_win [16];
    logic [31:0]  n_win [16];
    logic [31:0]  r_v [8];
    logic [31:0]  n_v [8];
    logic         r_ov, n_ov;
    t_out         r_out, n_out;

    logic         m_we;
    logic [3:0]   m_waddr, m_raddr;
    logic [31:0]  m_wdata, m_rdata;
    logic         c_we;
    logic [2:0]   c_waddr, c_raddr;
    logic [31:0]  c_wdata, c_rdata;

    logic         w_in_acc;
    logic [4:0]   w_prev;
    logic [31:0]  w_hv;
    logic [63:0]  w_total;
    logic         w_len_here;
    logic [31:0]  w_pad_word;
    logic [31:0]  w_t1, w_t2, w_wnext;

    sha256h_ram #(.WIDTH(32), .DEPTH(16)) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    sha256h_ram #(.WIDTH(32), .DEPTH(8)) u_chain_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_ov;
    assign o_out    = r_out;
    assign w_in_acc = i_valid && o_ready;

    assign w_prev     = r_cnt - 5'd1;
    assign w_hv       = r_h_init ? init_h(w_prev[2:0]) : c_rdata;
    assign w_total    = {r_blocks, r_fill, 3'b000};
    assign w_len_here = !r_pad_first || (r_fill < LEN_FILL_LIMIT);

    always_comb begin
        case (r_fill[1:0])
            2'd0:    w_pad_word = 32'h80000000;
            2'd1:    w_pad_word = {r_acc[7:0], 8'h80, 16'h0000};
            2'd2:    w_pad_word = {r_acc[15:0], 8'h80, 8'h00};
            default: w_pad_word = {r_acc[23:0], 8'h80};
        endcase
    end

    assign w_t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + round_k(r_rnd) + r_win[0];
    assign w_t2 = bsig0(r_v[0])
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_wnext = ssig1(r_win[14]) + r_win[9] + ssig0(r_win[1]) + r_win[0];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rnd       = r_rnd;
        n_widx      = r_widx;
        n_fill      = r_fill;
        n_blocks    = r_blocks;
        n_acc       = r_acc;
        n_h_init    = r_h_init;
        n_eom       = r_eom;
        n_pad_first = r_pad_first;
        n_fin_blk   = r_fin_blk;
        n_win       = r_win;
        n_v         = r_v;
        n_ov        = r_ov && !i_ready;
        n_out       = r_out;
        m_we        = 1'b0;
        m_waddr     = r_fill[5:2];
        m_wdata     = {r_acc, i_in.data_byte};
        m_raddr     = r_cnt[3:0];
        c_we        = 1'b0;
        c_waddr     = w_prev[2:0];
        c_wdata     = w_hv + r_v[0];
        c_raddr     = r_cnt[2:0];

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.end_of_message) begin
                        n_eom       = 1'b1;
                        n_pad_first = 1'b1;
                    end
                    if (i_in.byte_valid) begin
                        m_we   = (r_fill[1:0] == 2'd3);
                        n_acc  = {r_acc[15:0], i_in.data_byte};
                        n_fill = r_fill + 6'd1;
                    end
                    if (i_in.byte_valid && (r_fill == 6'd63)) begin
                        n_blocks = r_blocks + 55'd1;
                        n_cnt    = '0;
                        n_state  = ST_LOAD;
                    end else if (i_in.end_of_message) begin
                        n_widx  = n_fill[5:2];
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                m_we    = 1'b1;
                m_waddr = r_widx;
                if (r_pad_first && (r_widx == r_fill[5:2])) begin
                    m_wdata = w_pad_word;
                end else if (w_len_here && (r_widx == 4'd14)) begin
                    m_wdata = w_total[63:32];
                end else if (w_len_here && (r_widx == 4'd15)) begin
                    m_wdata = w_total[31:0];
                end else begin
                    m_wdata = '0;
                end
                if (r_widx == 4'd15) begin
                    n_fin_blk   = w_len_here;
                    n_pad_first = 1'b0;
                    n_cnt       = '0;
                    n_state     = ST_LOAD;
                end else begin
                    n_widx = r_widx + 4'd1;
                end
            end
            ST_LOAD: begin
                if (r_cnt != 5'd0) begin
                    for (int i = 0; i < 15; i++) begin
                        n_win[i] = r_win[i + 1];
                    end
                    n_win[15] = m_rdata;
                end
                if ((r_cnt != 5'd0) && (r_cnt <= 5'd8)) begin
                    for (int i = 0; i < 7; i++) begin
                        n_v[i] = r_v[i + 1];
                    end
                    n_v[7] = w_hv;
                end
                if (r_cnt == 5'd16) begin
                    n_rnd   = '0;
                    n_state = ST_ROUND;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_ROUND: begin
                n_v[0] = w_t1 + w_t2;
                n_v[1] = r_v[0];
                n_v[2] = r_v[1];
                n_v[3] = r_v[2];
                n_v[4] = r_v[3] + w_t1;
                n_v[5] = r_v[4];
                n_v[6] = r_v[5];
                n_v[7] = r_v[6];
                for (int i = 0; i < 15; i++) begin
                    n_win[i] = r_win[i + 1];
                end
                n_win[15] = w_wnext;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_cnt   = '0;
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (r_cnt != 5'd0) begin
                    c_we = 1'b1;
                    for (int i = 0; i < 7; i++) begin
                        n_v[i] = r_v[i + 1];
                    end
                    n_v[7] = c_wdata;
                end
                if (r_cnt == 5'd8) begin
                    n_h_init = 1'b0;
                    n_cnt    = '0;
                    if (r_fin_blk) begin
                        n_state = ST_OUT_RD;
                    end else if (r_eom) begin
                        n_widx  = r_pad_first ? r_fill[5:2] : 4'd0;
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_OUT_RD: begin
                n_state = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                if (!r_ov || i_ready) begin
                    n_ov              = 1'b1;
                    n_out.digest_word = c_rdata;
                    n_out.word_index  = r_cnt[2:0];
                    n_out.last_word   = (r_cnt[2:0] == 3'd7);
                    if (r_cnt[2:0] == 3'd7) begin
                        n_fill      = '0;
                        n_blocks    = '0;
                        n_h_init    = 1'b1;
                        n_eom       = 1'b0;
                        n_fin_blk   = 1'b0;
                        n_pad_first = 1'b0;
                        n_cnt       = '0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_cnt   = r_cnt + 5'd1;
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_rnd       <= '0;
            r_widx      <= '0;
            r_fill      <= '0;
            r_blocks    <= '0;
            r_h_init    <= 1'b1;
            r_eom       <= 1'b0;
            r_pad_first <= 1'b0;
            r_fin_blk   <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rnd       <= n_rnd;
            r_widx      <= n_widx;
            r_fill      <= n_fill;
            r_blocks    <= n_blocks;
            r_h_init    <= n_h_init;
            r_eom       <= n_eom;
            r_pad_first <= n_pad_first;
            r_fin_blk   <= n_fin_blk;
            r_ov        <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_win <= n_win;
        r_v   <= n_v;
        r_out <= n_out;
    end

endmodule

// ===== rtl/sha256h_checker.sv =====
// ============================================================================
// SHA-256 hasher port checker
// Watches the top-level ports of the hasher; bound to the top level below.
// ============================================================================
`include "sha256_hasher_unit_defines.svh"

module sha256h_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input sha256h_pkg::t_in   i_in,
    input logic               o_valid,
    input logic               i_ready,
    input sha256h_pkg::t_out  o_out
);

    `SHA256H_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_out)), "digest transaction dropped or changed while stalled")
    `SHA256H_ASSERT(a_last_flag, i_clk, i_rst_n, o_valid |-> (o_out.last_word == (o_out.word_index == 3'd7)), "last_word does not match word_index")
    `SHA256H_ASSERT(a_busy_mid_digest, i_clk, i_rst_n, (o_valid && !o_out.last_word) |-> !o_ready, "input taken while digest still streaming")
    `SHA256H_ASSERT(a_index_step, i_clk, i_rst_n, (o_valid && i_ready && !o_out.last_word) |=> (!o_valid || (o_out.word_index == ($past(o_out.word_index) + 3'd1))), "digest words out of order")
    `SHA256H_ASSERT_NR(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind sha256_hasher_unit sha256h_checker u_sha256h_checker (.*);
